@@ rtl/core/cvr_pkg.sv @@
// ============================================================================
// cvr_pkg
// Shared widths, codes and stage records of the collision velocity resolver.
// ============================================================================
package cvr_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;

    localparam int VAL_W     = 32;  // sign-extended coordinate or velocity
    localparam int D_W       = 33;  // difference of two coordinates
    localparam int N_W       = 34;  // raw contact normal
    localparam int SQ_W      = 66;  // square of a D_W magnitude
    localparam int LEN_W     = 67;  // squared length
    localparam int NORM_BITS = 14;  // reduced normal magnitude bits
    localparam int NR_W      = 15;  // reduced normal, signed
    localparam int DOT_W     = 48;
    localparam int DD_W      = 49;
    localparam int SM_W      = 29;
    localparam int MSUM_W    = 33;
    localparam int PROD_W    = 64;
    localparam int PMAG_W    = 62;
    localparam int Q_W       = 34;  // quotient bits, also divider depth
    localparam int MDIV_W    = 48;
    localparam int FRAC_BITS = 16;
    localparam int RATIO_W   = 17;

    typedef enum logic
    {
        KIND_BOX    = 1'b0,
        KIND_CIRCLE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        OUT_NONE       = 2'd0,
        OUT_SEPARATING = 2'd1,
        OUT_RESOLVED   = 2'd2,
        OUT_DEGENERATE = 2'd3
    } outcome_t;

    typedef enum logic [1:0]
    {
        MODE_BOX_BOX       = 2'd0,
        MODE_CIRCLE_CIRCLE = 2'd1,
        MODE_BOX_CIRCLE    = 2'd2
    } mode_t;

    localparam logic signed [1:0] AXIS_NX [4] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};
    localparam logic signed [1:0] AXIS_NY [4] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1};

    typedef struct packed
    {
        logic signed [VAL_W-1:0] v1x;
        logic signed [VAL_W-1:0] v1y;
        logic signed [VAL_W-1:0] v2x;
        logic signed [VAL_W-1:0] v2y;
        logic        [31:0]      m1;
        logic        [31:0]      m2;
        logic                    st1;
        logic                    st2;
    } cvr_side_t;

    typedef struct packed
    {
        logic                  contact;
        logic signed [N_W-1:0] nx;
        logic signed [N_W-1:0] ny;
        cvr_side_t             side;
    } cvr_contact_t;

    typedef struct packed
    {
        outcome_t                outcome;
        logic                    sx;
        logic                    sy;
        logic signed [VAL_W-1:0] v1x;
        logic signed [VAL_W-1:0] v1y;
        logic signed [VAL_W-1:0] v2x;
        logic signed [VAL_W-1:0] v2y;
        logic                    st1;
        logic                    st2;
    } cvr_track_t;

    typedef struct packed
    {
        logic [Q_W-1:0] qx_mag;
        logic [Q_W-1:0] qy_mag;
        logic [Q_W-1:0] ratio;
        logic           ratio_inexact;
    } cvr_quot_t;

endpackage

@@ rtl/core/cvr_pair_if.sv @@
// ============================================================================
// cvr_pair_if
// Collider pair channel: valid, ready and the two collider records.
// ============================================================================
interface cvr_pair_if;
    logic        valid;
    logic        ready;
    logic        first_kind;
    logic [63:0] first_point_a;
    logic [63:0] first_point_b;
    logic [63:0] first_velocity;
    logic [31:0] first_mass;
    logic        first_static;
    logic        second_kind;
    logic [63:0] second_point_a;
    logic [63:0] second_point_b;
    logic [63:0] second_velocity;
    logic [31:0] second_mass;
    logic        second_static;

    modport source
    (
        output valid, first_kind, first_point_a, first_point_b, first_velocity,
               first_mass, first_static, second_kind, second_point_a,
               second_point_b, second_velocity, second_mass, second_static,
        input  ready
    );

    modport sink
    (
        input  valid, first_kind, first_point_a, first_point_b, first_velocity,
               first_mass, first_static, second_kind, second_point_a,
               second_point_b, second_velocity, second_mass, second_static,
        output ready
    );
endinterface

@@ rtl/core/cvr_result_if.sv @@
// ============================================================================
// cvr_result_if
// Result channel: valid, ready, both new velocities and the outcome code.
// ============================================================================
interface cvr_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] first_new_velocity;
    logic [63:0] second_new_velocity;
    logic [1:0]  outcome;

    modport source
    (
        output valid, first_new_velocity, second_new_velocity, outcome,
        input  ready
    );

    modport sink
    (
        input  valid, first_new_velocity, second_new_velocity, outcome,
        output ready
    );
endinterface

@@ rtl/core/cvr_contact.sv @@
// ============================================================================
// cvr_contact
// Three-stage contact test: unpack and edge deltas, squares, nearest pick.
// ============================================================================
module cvr_contact
    import cvr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           en,
    cvr_pair_if.sink       pair,
    output cvr_contact_t   contact
);

    typedef struct packed
    {
        mode_t                 mode;
        logic                  bb_contact;
        logic signed [1:0]     bb_nx;
        logic signed [1:0]     bb_ny;
        logic                  negate;
        logic signed [D_W-1:0] rad;
        logic [3:0][D_W-1:0]   dx;
        logic [3:0][D_W-1:0]   dy;
        cvr_side_t             side;
    } stage_a_t;

    typedef struct packed
    {
        mode_t                 mode;
        logic                  bb_contact;
        logic signed [1:0]     bb_nx;
        logic signed [1:0]     bb_ny;
        logic                  negate;
        logic                  rad_neg;
        logic [SQ_W-1:0]       rsq;
        logic [3:0][D_W-1:0]   dx;
        logic [3:0][D_W-1:0]   dy;
        logic [3:0][SQ_W-1:0]  sqx;
        logic [3:0][SQ_W-1:0]  sqy;
        cvr_side_t             side;
    } stage_b_t;

    function automatic logic signed [VAL_W-1:0] sext(input logic [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] t;
        t = $signed(v << (VAL_W - COORD_WIDTH));
        return t >>> (VAL_W - COORD_WIDTH);
    endfunction

    function automatic logic [D_W-1:0] mag(input logic [D_W-1:0] v);
        return v[D_W-1] ? D_W'(-$signed(v)) : v;
    endfunction

    stage_a_t a_next, a_reg;
    stage_b_t b_next, b_reg;
    cvr_contact_t c_next, c_reg;

    logic signed [VAL_W-1:0] a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;
    logic signed [VAL_W-1:0] lbx, lby, rtx, rty, ox, oy, rr;
    logic signed [VAL_W-1:0] lox, hix, loy, hiy, cx, cy;
    logic signed [35:0] cdx, cdy, sx, sy, ex, ey;
    logic [1:0] axis;
    logic box_first;

    always_comb
    begin
        a1x = sext(pair.first_point_a[31:0]);
        a1y = sext(pair.first_point_a[63:32]);
        b1x = sext(pair.first_point_b[31:0]);
        b1y = sext(pair.first_point_b[63:32]);
        a2x = sext(pair.second_point_a[31:0]);
        a2y = sext(pair.second_point_a[63:32]);
        b2x = sext(pair.second_point_b[31:0]);
        b2y = sext(pair.second_point_b[63:32]);

        cdx = (36'(a2x) + 36'(b2x)) - (36'(a1x) + 36'(b1x));
        cdy = (36'(a2y) + 36'(b2y)) - (36'(a1y) + 36'(b1y));
        sx  = (36'(b1x) - 36'(a1x)) + (36'(b2x) - 36'(a2x));
        sy  = (36'(b1y) - 36'(a1y)) + (36'(b2y) - 36'(a2y));
        ex  = (cdx < 0 ? -cdx : cdx) - sx;
        ey  = (cdy < 0 ? -cdy : cdy) - sy;
        if (ex > ey)
        begin
            axis = (cdx > 0) ? 2'd0 : 2'd1;
        end
        else
        begin
            axis = (cdy > 0) ? 2'd2 : 2'd3;
        end

        box_first = (pair.first_kind == KIND_BOX);
        lbx = box_first ? a1x : a2x;
        lby = box_first ? a1y : a2y;
        rtx = box_first ? b1x : b2x;
        rty = box_first ? b1y : b2y;
        ox  = box_first ? a2x : a1x;
        oy  = box_first ? a2y : a1y;
        rr  = box_first ? b2x : b1x;
        lox = (lbx < rtx) ? lbx : rtx;
        hix = (lbx < rtx) ? rtx : lbx;
        loy = (lby < rty) ? lby : rty;
        hiy = (lby < rty) ? rty : lby;
        cx  = (ox < lox) ? lox : ((ox > hix) ? hix : ox);
        cy  = (oy < loy) ? loy : ((oy > hiy) ? hiy : oy);

        if (pair.first_kind == KIND_BOX && pair.second_kind == KIND_BOX)
        begin
            a_next.mode = MODE_BOX_BOX;
        end
        else if (pair.first_kind == KIND_CIRCLE && pair.second_kind == KIND_CIRCLE)
        begin
            a_next.mode = MODE_CIRCLE_CIRCLE;
        end
        else
        begin
            a_next.mode = MODE_BOX_CIRCLE;
        end

        a_next.bb_contact = (a1x <= b2x) && (a2x <= b1x) && (a1y <= b2y) && (a2y <= b1y);
        a_next.bb_nx  = AXIS_NX[axis];
        a_next.bb_ny  = AXIS_NY[axis];
        a_next.negate = (a_next.mode == MODE_BOX_CIRCLE) && !box_first;

        if (a_next.mode == MODE_CIRCLE_CIRCLE)
        begin
            a_next.rad   = D_W'(b1x) + D_W'(b2x);
            a_next.dx[0] = D_W'(a1x) - D_W'(a2x);
            a_next.dy[0] = D_W'(a1y) - D_W'(a2y);
        end
        else
        begin
            a_next.rad   = D_W'(rr);
            a_next.dx[0] = D_W'(lbx) - D_W'(ox);
            a_next.dy[0] = D_W'(cy) - D_W'(oy);
        end
        a_next.dx[1] = D_W'(rtx) - D_W'(ox);
        a_next.dy[1] = D_W'(cy) - D_W'(oy);
        a_next.dx[2] = D_W'(cx) - D_W'(ox);
        a_next.dy[2] = D_W'(lby) - D_W'(oy);
        a_next.dx[3] = D_W'(cx) - D_W'(ox);
        a_next.dy[3] = D_W'(rty) - D_W'(oy);

        a_next.side.v1x = sext(pair.first_velocity[31:0]);
        a_next.side.v1y = sext(pair.first_velocity[63:32]);
        a_next.side.v2x = sext(pair.second_velocity[31:0]);
        a_next.side.v2y = sext(pair.second_velocity[63:32]);
        a_next.side.m1  = pair.first_mass;
        a_next.side.m2  = pair.second_mass;
        a_next.side.st1 = pair.first_static;
        a_next.side.st2 = pair.second_static;
    end

    always_comb
    begin
        b_next.mode       = a_reg.mode;
        b_next.bb_contact = a_reg.bb_contact;
        b_next.bb_nx      = a_reg.bb_nx;
        b_next.bb_ny      = a_reg.bb_ny;
        b_next.negate     = a_reg.negate;
        b_next.rad_neg    = a_reg.rad[D_W-1];
        b_next.rsq        = SQ_W'(mag(a_reg.rad)) * SQ_W'(mag(a_reg.rad));
        b_next.dx         = a_reg.dx;
        b_next.dy         = a_reg.dy;
        for (int i = 0; i < 4; i++)
        begin
            b_next.sqx[i] = SQ_W'(mag(a_reg.dx[i])) * SQ_W'(mag(a_reg.dx[i]));
            b_next.sqy[i] = SQ_W'(mag(a_reg.dy[i])) * SQ_W'(mag(a_reg.dy[i]));
        end
        b_next.side = a_reg.side;
    end

    logic [LEN_W-1:0] len [4];
    logic [LEN_W-1:0] len_lo, len_hi, len_min;
    logic [1:0] idx_lo, idx_hi, idx_min;
    logic signed [N_W-1:0] dsel_x, dsel_y;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            len[i] = LEN_W'(b_reg.sqx[i]) + LEN_W'(b_reg.sqy[i]);
        end
        idx_lo  = (len[0] < len[1]) ? 2'd0 : 2'd1;
        len_lo  = (len[0] < len[1]) ? len[0] : len[1];
        idx_hi  = (len[2] < len[3]) ? 2'd2 : 2'd3;
        len_hi  = (len[2] < len[3]) ? len[2] : len[3];
        idx_min = (len_lo < len_hi) ? idx_lo : idx_hi;
        len_min = (len_lo < len_hi) ? len_lo : len_hi;

        dsel_x = N_W'($signed(b_reg.dx[idx_min]));
        dsel_y = N_W'($signed(b_reg.dy[idx_min]));

        c_next.side = b_reg.side;
        case (b_reg.mode)
            MODE_BOX_BOX:
            begin
                c_next.contact = b_reg.bb_contact;
                c_next.nx      = N_W'(b_reg.bb_nx);
                c_next.ny      = N_W'(b_reg.bb_ny);
            end
            MODE_CIRCLE_CIRCLE:
            begin
                c_next.contact = !b_reg.rad_neg && !(LEN_W'(b_reg.rsq) < len[0]);
                c_next.nx      = N_W'($signed(b_reg.dx[0]));
                c_next.ny      = N_W'($signed(b_reg.dy[0]));
            end
            MODE_BOX_CIRCLE:
            begin
                c_next.contact = !b_reg.rad_neg && !(LEN_W'(b_reg.rsq) < len_min);
                c_next.nx      = b_reg.negate ? -dsel_x : dsel_x;
                c_next.ny      = b_reg.negate ? -dsel_y : dsel_y;
            end
            default:
            begin
                c_next.contact = 1'b0;
                c_next.nx      = '0;
                c_next.ny      = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign contact = c_reg;

endmodule

@@ rtl/core/cvr_divider.sv @@
// ============================================================================
// cvr_divider
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module cvr_divider
    import cvr_pkg::*;
#(
    parameter int ND = PMAG_W,
    parameter int DW = SM_W,
    parameter int QW = Q_W
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [ND-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient,
    output logic          rem_nz
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] num_reg [QW];
    logic [DW-1:0] div_reg [QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [QW-1:0] num_in;
        logic [DW-1:0] div_in;
        logic [DW+1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_in = DW'(dividend >> QW);
            assign num_in = dividend[QW-1:0];
            assign div_in = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign div_in = div_reg[k-1];
        end

        assign trial = {1'b0, rem_in, num_in[QW-1]} - {2'b00, div_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= trial[DW+1] ? {rem_in[DW-2:0], num_in[QW-1]} : trial[DW-1:0];
                num_reg[k] <= {num_in[QW-2:0], !trial[DW+1]};
            end
        end

        if (k < QW - 1)
        begin : g_div
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    div_reg[k] <= div_in;
                end
            end
        end
    end

    assign quotient = num_reg[QW-1];
    assign rem_nz   = |rem_reg[QW-1];

endmodule

@@ rtl/core/cvr_update.sv @@
// ============================================================================
// cvr_update
// Two-stage velocity update: mass-weighted products, then apply and saturate.
// ============================================================================
module cvr_update
    import cvr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        en,
    input  cvr_track_t  track,
    input  cvr_quot_t   quot,
    output logic [63:0] first_new_velocity,
    output logic [63:0] second_new_velocity,
    output outcome_t    outcome
);

    localparam int QS_W  = Q_W + 1;
    localparam int P_W   = 53;
    localparam int T_W   = P_W + 1 - FRAC_BITS;
    localparam int RES_W = 40;
    localparam logic signed [RES_W-1:0] SAT_MAX =
        RES_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

    typedef struct packed
    {
        cvr_track_t             track;
        logic signed [QS_W-1:0] qx;
        logic signed [QS_W-1:0] qy;
        logic signed [P_W-1:0]  p1x;
        logic signed [P_W-1:0]  p1y;
        logic signed [P_W-1:0]  p2x;
        logic signed [P_W-1:0]  p2y;
    } stage_g_t;

    function automatic logic signed [T_W-1:0] trunc_frac(input logic signed [P_W-1:0] p);
        logic signed [P_W:0] t;
        t = {p, 1'b0};
        if (t < 0)
        begin
            t = t + (P_W+1)'((1 << FRAC_BITS) - 1);
        end
        return T_W'(t >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] sat(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] s;
        s = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
        return s[31:0];
    endfunction

    stage_g_t g_next, g_reg;
    logic signed [RATIO_W:0] r1, r2;
    logic signed [RES_W-1:0] n1x, n1y, n2x, n2y;
    logic [63:0] v1_next, v2_next;
    logic [63:0] v1_reg, v2_reg;
    outcome_t outcome_reg;

    always_comb
    begin
        r1 = $signed({1'b0, quot.ratio[RATIO_W-1:0]});
        r2 = (RATIO_W+1)'(1 << FRAC_BITS) - r1 - (RATIO_W+1)'(quot.ratio_inexact);
        g_next.track = track;
        g_next.qx = track.sx ? -$signed({1'b0, quot.qx_mag}) : $signed({1'b0, quot.qx_mag});
        g_next.qy = track.sy ? -$signed({1'b0, quot.qy_mag}) : $signed({1'b0, quot.qy_mag});
        g_next.p1x = P_W'(r2) * P_W'(g_next.qx);
        g_next.p1y = P_W'(r2) * P_W'(g_next.qy);
        g_next.p2x = P_W'(r1) * P_W'(g_next.qx);
        g_next.p2y = P_W'(r1) * P_W'(g_next.qy);
    end

    always_comb
    begin
        n1x = RES_W'(g_reg.track.v1x);
        n1y = RES_W'(g_reg.track.v1y);
        n2x = RES_W'(g_reg.track.v2x);
        n2y = RES_W'(g_reg.track.v2y);
        if (g_reg.track.outcome == OUT_RESOLVED)
        begin
            if (!g_reg.track.st1 && !g_reg.track.st2)
            begin
                n1x = n1x - RES_W'(trunc_frac(g_reg.p1x));
                n1y = n1y - RES_W'(trunc_frac(g_reg.p1y));
                n2x = n2x + RES_W'(trunc_frac(g_reg.p2x));
                n2y = n2y + RES_W'(trunc_frac(g_reg.p2y));
            end
            else if (!g_reg.track.st2)
            begin
                n2x = n2x + (RES_W'(g_reg.qx) <<< 1);
                n2y = n2y + (RES_W'(g_reg.qy) <<< 1);
            end
            else if (!g_reg.track.st1)
            begin
                n1x = n1x - (RES_W'(g_reg.qx) <<< 1);
                n1y = n1y - (RES_W'(g_reg.qy) <<< 1);
            end
        end
        v1_next = {sat(n1y), sat(n1x)};
        v2_next = {sat(n2y), sat(n2x)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg       <= g_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            outcome_reg <= g_reg.track.outcome;
        end
    end

    assign first_new_velocity  = v1_reg;
    assign second_new_velocity = v2_reg;
    assign outcome             = outcome_reg;

endmodule

@@ rtl/core/collision_velocity_resolver_unit.sv @@
// ============================================================================
// collision_velocity_resolver_unit
// Contact test and elastic velocity response for one collider pair per beat.
// ============================================================================
// Accepts one collider pair every cycle while not stalled and returns its result
// beat after three stages of contact test, normal reduction, dot products and
// products, 34 stages of the shared-depth restoring dividers (impulse and mass
// ratio in parallel, one quotient bit per stage), and two stages of update with
// the output register. A low ready on the result channel while a result beat waits
// holds the whole pipeline in place, and pair.ready follows it in the same cycle.
module collision_velocity_resolver_unit
    import cvr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    cvr_pair_if.sink     pair,
    cvr_result_if.source result
);

    localparam int LAT = 3 + 3 + Q_W + 2;

    typedef struct packed
    {
        outcome_t               outcome;
        logic signed [NR_W-1:0] nx;
        logic signed [NR_W-1:0] ny;
        cvr_side_t              side;
    } stage_d_t;

    typedef struct packed
    {
        outcome_t               outcome;
        logic signed [NR_W-1:0] nx;
        logic signed [DD_W-1:0] dd;
        logic signed [NR_W-1:0] ny;
        logic [SM_W-1:0]        sm;
        logic [MSUM_W-1:0]      msum;
        cvr_side_t              side;
    } stage_e_t;

    typedef struct packed
    {
        logic [PMAG_W-1:0] pxm;
        logic [PMAG_W-1:0] pym;
        logic [SM_W-1:0]   sm;
        logic [MSUM_W-1:0] msum;
        logic [MDIV_W-1:0] mdiv;
        cvr_track_t        track;
    } stage_f_t;

    logic en;
    logic [LAT-1:0] vld_reg;
    cvr_contact_t contact;
    stage_d_t d_next, d_reg;
    stage_e_t e_next, e_reg;
    stage_f_t f_next, f_reg;
    cvr_track_t track_reg [Q_W];
    cvr_quot_t quot;

    assign en         = !vld_reg[LAT-1] || result.ready;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pair.valid};
        end
    end

    cvr_contact #(.COORD_WIDTH(COORD_WIDTH)) u_contact
    (
        .clk     (clk),
        .en      (en),
        .pair    (pair),
        .contact (contact)
    );

    logic [D_W-1:0] ax, ay, am;
    logic [5:0] msb, sh;
    logic [NORM_BITS-1:0] rx, ry;

    always_comb
    begin
        ax = contact.nx[N_W-1] ? D_W'(-contact.nx) : D_W'(contact.nx);
        ay = contact.ny[N_W-1] ? D_W'(-contact.ny) : D_W'(contact.ny);
        am = ax | ay;
        msb = '0;
        for (int i = 0; i < D_W; i++)
        begin
            if (am[i])
            begin
                msb = 6'(i);
            end
        end
        sh = (msb >= 6'(NORM_BITS)) ? msb - 6'(NORM_BITS - 1) : 6'd0;
        rx = NORM_BITS'(ax >> sh);
        ry = NORM_BITS'(ay >> sh);
        d_next.nx = contact.nx[N_W-1] ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        d_next.ny = contact.ny[N_W-1] ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
        d_next.side = contact.side;
        if (!contact.contact)
        begin
            d_next.outcome = OUT_NONE;
        end
        else if (rx == '0 && ry == '0)
        begin
            d_next.outcome = OUT_DEGENERATE;
        end
        else
        begin
            d_next.outcome = OUT_RESOLVED;
        end
    end

    logic signed [DOT_W-1:0] dot1, dot2;
    logic signed [D_W-1:0] dvx, dvy;
    logic signed [SM_W:0] sm_full;

    always_comb
    begin
        dot1 = DOT_W'(d_reg.nx) * DOT_W'(d_reg.side.v1x)
             + DOT_W'(d_reg.ny) * DOT_W'(d_reg.side.v1y);
        dot2 = DOT_W'(d_reg.nx) * DOT_W'(d_reg.side.v2x)
             + DOT_W'(d_reg.ny) * DOT_W'(d_reg.side.v2y);
        dvx = D_W'(d_reg.side.v1x) - D_W'(d_reg.side.v2x);
        dvy = D_W'(d_reg.side.v1y) - D_W'(d_reg.side.v2y);
        sm_full = (SM_W+1)'(d_reg.nx) * (SM_W+1)'(d_reg.nx)
                + (SM_W+1)'(d_reg.ny) * (SM_W+1)'(d_reg.ny);
        e_next.nx   = d_reg.nx;
        e_next.ny   = d_reg.ny;
        e_next.dd   = DD_W'(dvx) * DD_W'(d_reg.nx) + DD_W'(dvy) * DD_W'(d_reg.ny);
        e_next.sm   = sm_full[SM_W-1:0];
        e_next.msum = MSUM_W'(d_reg.side.m1) + MSUM_W'(d_reg.side.m2);
        e_next.side = d_reg.side;
        e_next.outcome = d_reg.outcome;
        if (d_reg.outcome == OUT_RESOLVED)
        begin
            if (dot1 >= 0 && dot2 <= 0)
            begin
                e_next.outcome = OUT_SEPARATING;
            end
            else if (!d_reg.side.st1 && !d_reg.side.st2 && e_next.msum == '0)
            begin
                e_next.outcome = OUT_DEGENERATE;
            end
        end
    end

    logic signed [PROD_W-1:0] px, py;

    always_comb
    begin
        px = PROD_W'(e_reg.dd) * PROD_W'(e_reg.nx);
        py = PROD_W'(e_reg.dd) * PROD_W'(e_reg.ny);
        f_next.pxm  = px[PROD_W-1] ? PMAG_W'(-px) : PMAG_W'(px);
        f_next.pym  = py[PROD_W-1] ? PMAG_W'(-py) : PMAG_W'(py);
        f_next.sm   = e_reg.sm;
        f_next.msum = e_reg.msum;
        f_next.mdiv = {e_reg.side.m1, {FRAC_BITS{1'b0}}};
        f_next.track.outcome = e_reg.outcome;
        f_next.track.sx  = px[PROD_W-1];
        f_next.track.sy  = py[PROD_W-1];
        f_next.track.v1x = e_reg.side.v1x;
        f_next.track.v1y = e_reg.side.v1y;
        f_next.track.v2x = e_reg.side.v2x;
        f_next.track.v2y = e_reg.side.v2y;
        f_next.track.st1 = e_reg.side.st1;
        f_next.track.st2 = e_reg.side.st2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
            track_reg[0] <= f_reg.track;
            for (int k = 1; k < Q_W; k++)
            begin
                track_reg[k] <= track_reg[k-1];
            end
        end
    end

    logic unused_x_nz, unused_y_nz;

    cvr_divider #(.ND(PMAG_W), .DW(SM_W), .QW(Q_W)) u_div_x
    (
        .clk      (clk),
        .en       (en),
        .dividend (f_reg.pxm),
        .divisor  (f_reg.sm),
        .quotient (quot.qx_mag),
        .rem_nz   (unused_x_nz)
    );

    cvr_divider #(.ND(PMAG_W), .DW(SM_W), .QW(Q_W)) u_div_y
    (
        .clk      (clk),
        .en       (en),
        .dividend (f_reg.pym),
        .divisor  (f_reg.sm),
        .quotient (quot.qy_mag),
        .rem_nz   (unused_y_nz)
    );

    cvr_divider #(.ND(MDIV_W), .DW(MSUM_W), .QW(Q_W)) u_div_mass
    (
        .clk      (clk),
        .en       (en),
        .dividend (f_reg.mdiv),
        .divisor  (f_reg.msum),
        .quotient (quot.ratio),
        .rem_nz   (quot.ratio_inexact)
    );

    outcome_t out_outcome;

    cvr_update #(.COORD_WIDTH(COORD_WIDTH)) u_update
    (
        .clk                 (clk),
        .en                  (en),
        .track               (track_reg[Q_W-1]),
        .quot                (quot),
        .first_new_velocity  (result.first_new_velocity),
        .second_new_velocity (result.second_new_velocity),
        .outcome             (out_outcome)
    );

    assign result.valid   = vld_reg[LAT-1];
    assign result.outcome = out_outcome;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pair.ready |=> $stable(vld_reg))
        else $error("pipeline valid line moved during a stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pair.valid && pair.ready |=> vld_reg[0])
        else $error("accepted pair did not enter the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result.valid) |-> $past(result.ready))
        else $error("result beat dropped without being taken");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg == '0 |-> pair.ready)
        else $error("empty pipeline refused a pair");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the collision velocity resolver unit.
// ============================================================================
// Streams collider pairs through the pair channel: a directed set of corner
// cases, then random box and circle pairs.
// Each accepted pair is run through a local response model and the new
// velocities and outcome are checked against the result beats in order.
// Both channels idle at random, the result side holds off once for a long
// stretch, and the pair side once drains the pipeline before going on.
module tb_top;
    import cvr_pkg::*;

    typedef struct
    {
        logic        k1;
        logic [63:0] pa1;
        logic [63:0] pb1;
        logic [63:0] vel1;
        logic [31:0] m1;
        logic        s1;
        logic        k2;
        logic [63:0] pa2;
        logic [63:0] pb2;
        logic [63:0] vel2;
        logic [31:0] m2;
        logic        s2;
    } pair_beat_t;

    typedef struct
    {
        logic [63:0] nv1;
        logic [63:0] nv2;
        outcome_t    oc;
    } response_t;

    typedef struct
    {
        longint x;
        longint y;
    } vec_t;

    localparam int DRAIN_POINT = 700;
    localparam int HOLD_POINT  = 400;
    localparam int HOLD_CYCLES = 250;
    localparam int WATCHDOG    = 3000;

    logic clk;
    logic rst_n;

    cvr_pair_if   pif();
    cvr_result_if rif();

    collision_velocity_resolver_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pif),
        .result (rif)
    );

    pair_beat_t pair_q[$];
    response_t  response_q[$];
    int         failures;
    int         pairs_sent;
    int         idle_cycles;
    int         src_gap;
    int         snk_gap;
    int         hold_left;
    bit         hold_done;
    logic       pair_taken;

    always #5 clk = ~clk;

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic vec_t unpack_pt(logic [63:0] p);
        vec_t r;
        r.x = sx32(p[31:0]);
        r.y = sx32(p[63:32]);
        return r;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sh7fffffff)
            return 32'h7fffffff;
        if (v < -64'sh80000000)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [66:0] len_sq(longint x, longint y);
        logic [66:0] ax;
        logic [66:0] ay;
        ax = 67'(x < 0 ? -x : x);
        ay = 67'(y < 0 ? -y : y);
        return ax * ax + ay * ay;
    endfunction

    function automatic longint clamp_to(longint v, longint e0, longint e1);
        longint lo;
        longint hi;
        lo = e0 < e1 ? e0 : e1;
        hi = e0 < e1 ? e1 : e0;
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic vec_t closer(vec_t a, vec_t b);
        return (len_sq(a.x, a.y) < len_sq(b.x, b.y)) ? a : b;
    endfunction

    function automatic vec_t mk_vec(longint x, longint y);
        vec_t r;
        r.x = x;
        r.y = y;
        return r;
    endfunction

    function automatic response_t resolve_pair(pair_beat_t p);
        response_t res;
        vec_t      a1, b1, v1, a2, b2, v2, nrm, lb, rt, o, d;
        longint    cdx, cdy, ex, ey, rad, ax, ay, sm, dd, qx, qy, msum, r1, r2;
        int        idx;
        bit        contact;
        a1 = unpack_pt(p.pa1);
        b1 = unpack_pt(p.pb1);
        v1 = unpack_pt(p.vel1);
        a2 = unpack_pt(p.pa2);
        b2 = unpack_pt(p.pb2);
        v2 = unpack_pt(p.vel2);
        if (p.k1 == KIND_BOX && p.k2 == KIND_BOX)
        begin
            contact = a1.x <= b2.x && a2.x <= b1.x && a1.y <= b2.y && a2.y <= b1.y;
            cdx = (a2.x + b2.x) - (a1.x + b1.x);
            cdy = (a2.y + b2.y) - (a1.y + b1.y);
            ex = (cdx < 0 ? -cdx : cdx) - ((b1.x - a1.x) + (b2.x - a2.x));
            ey = (cdy < 0 ? -cdy : cdy) - ((b1.y - a1.y) + (b2.y - a2.y));
            idx = (ex > ey) ? (cdx > 0 ? 0 : 1) : (cdy > 0 ? 2 : 3);
            nrm = mk_vec(longint'(AXIS_NX[idx]), longint'(AXIS_NY[idx]));
        end
        else if (p.k1 == KIND_CIRCLE && p.k2 == KIND_CIRCLE)
        begin
            rad = b1.x + b2.x;
            nrm = mk_vec(a1.x - a2.x, a1.y - a2.y);
            contact = rad >= 0 && !(len_sq(rad, 0) < len_sq(nrm.x, nrm.y));
        end
        else
        begin
            lb = p.k1 == KIND_BOX ? a1 : a2;
            rt = p.k1 == KIND_BOX ? b1 : b2;
            o = p.k1 == KIND_BOX ? a2 : a1;
            rad = p.k1 == KIND_BOX ? b2.x : b1.x;
            ax = clamp_to(o.x, lb.x, rt.x);
            ay = clamp_to(o.y, lb.y, rt.y);
            d = closer(closer(mk_vec(lb.x - o.x, ay - o.y), mk_vec(rt.x - o.x, ay - o.y)),
                       closer(mk_vec(ax - o.x, lb.y - o.y), mk_vec(ax - o.x, rt.y - o.y)));
            contact = rad >= 0 && !(len_sq(rad, 0) < len_sq(d.x, d.y));
            nrm = p.k1 == KIND_BOX ? d : mk_vec(-d.x, -d.y);
        end

        if (!contact)
            res.oc = OUT_NONE;
        else
        begin
            ax = nrm.x < 0 ? -nrm.x : nrm.x;
            ay = nrm.y < 0 ? -nrm.y : nrm.y;
            while (ax >= (1 << NORM_BITS) || ay >= (1 << NORM_BITS))
            begin
                ax = ax >>> 1;
                ay = ay >>> 1;
            end
            nrm.x = nrm.x < 0 ? -ax : ax;
            nrm.y = nrm.y < 0 ? -ay : ay;
            if (nrm.x == 0 && nrm.y == 0)
                res.oc = OUT_DEGENERATE;
            else if (nrm.x * v1.x + nrm.y * v1.y >= 0 && nrm.x * v2.x + nrm.y * v2.y <= 0)
                res.oc = OUT_SEPARATING;
            else
            begin
                sm = nrm.x * nrm.x + nrm.y * nrm.y;
                dd = (v1.x - v2.x) * nrm.x + (v1.y - v2.y) * nrm.y;
                qx = (dd * nrm.x) / sm;
                qy = (dd * nrm.y) / sm;
                res.oc = OUT_RESOLVED;
                if (!p.s1 && !p.s2)
                begin
                    msum = longint'(p.m1) + longint'(p.m2);
                    if (msum == 0)
                        res.oc = OUT_DEGENERATE;
                    else
                    begin
                        r1 = (longint'(p.m1) << 16) / msum;
                        r2 = (longint'(p.m2) << 16) / msum;
                        v1.x -= (2 * r2 * qx) / 65536;
                        v1.y -= (2 * r2 * qy) / 65536;
                        v2.x += (2 * r1 * qx) / 65536;
                        v2.y += (2 * r1 * qy) / 65536;
                    end
                end
                else if (!p.s2)
                begin
                    v2.x += 2 * qx;
                    v2.y += 2 * qy;
                end
                else if (!p.s1)
                begin
                    v1.x -= 2 * qx;
                    v1.y -= 2 * qy;
                end
            end
        end
        res.nv1 = {sat32(v1.y), sat32(v1.x)};
        res.nv2 = {sat32(v2.y), sat32(v2.x)};
        return res;
    endfunction

    function automatic logic [63:0] pt(int x, int y);
        return {y[31:0], x[31:0]};
    endfunction

    function automatic pair_beat_t mk_pair(logic k1, logic [63:0] pa1, logic [63:0] pb1,
                                           logic [63:0] vel1, logic [31:0] m1, logic s1,
                                           logic k2, logic [63:0] pa2, logic [63:0] pb2,
                                           logic [63:0] vel2, logic [31:0] m2, logic s2);
        pair_beat_t p;
        p = '{k1, pa1, pb1, vel1, m1, s1, k2, pa2, pb2, vel2, m2, s2};
        return p;
    endfunction

    function automatic logic [31:0] rnd_coord(int span);
        if (span == 0)
            return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [63:0] rnd_shape(logic kind, logic [63:0] pa, int span);
        logic [31:0] w;
        logic [31:0] h;
        w = (span == 0) ? $urandom : $urandom_range(0, span);
        h = (span == 0) ? $urandom : $urandom_range(0, span);
        if (kind == KIND_CIRCLE)
            return {$urandom, ($urandom_range(0, 15) == 0) ? -w : w};
        if ($urandom_range(0, 15) == 0)
            return {pa[63:32] - h, pa[31:0] - w};
        return {pa[63:32] + h, pa[31:0] + w};
    endfunction

    function automatic pair_beat_t rnd_pair();
        pair_beat_t p;
        int         span;
        int         vspan;
        int         sel;
        if ($urandom_range(0, 9) == 0)
            return mk_pair($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom, $urandom,
                           $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom, $urandom);
        sel = $urandom_range(0, 9);
        span = sel < 4 ? 400 : (sel < 7 ? 1 << 18 : (sel < 9 ? 1 << 28 : 0));
        sel = $urandom_range(0, 9);
        vspan = sel < 5 ? 1 << 17 : (sel < 8 ? 1 << 24 : 0);
        p.k1 = $urandom;
        p.k2 = $urandom;
        p.pa1 = {rnd_coord(span), rnd_coord(span)};
        p.pa2 = {rnd_coord(span), rnd_coord(span)};
        p.pb1 = rnd_shape(p.k1, p.pa1, span);
        p.pb2 = rnd_shape(p.k2, p.pa2, span);
        p.vel1 = {rnd_coord(vspan), rnd_coord(vspan)};
        p.vel2 = {rnd_coord(vspan), rnd_coord(vspan)};
        sel = $urandom_range(0, 9);
        p.m1 = sel == 0 ? 32'd0 : (sel < 7 ? $urandom_range(1, 1 << 20) : $urandom);
        sel = $urandom_range(0, 9);
        p.m2 = sel == 0 ? 32'd0 : (sel < 7 ? $urandom_range(1, 1 << 20) : $urandom);
        p.s1 = $urandom_range(0, 4) == 0;
        p.s2 = $urandom_range(0, 4) == 0;
        return p;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            failures++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        failures = 0;
        pairs_sent = 0;
        idle_cycles = 0;
        src_gap = 0;
        snk_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pair_taken = 1'b0;
        pif.valid = 1'b0;
        pif.first_kind = 1'b0;
        pif.first_point_a = '0;
        pif.first_point_b = '0;
        pif.first_velocity = '0;
        pif.first_mass = '0;
        pif.first_static = 1'b0;
        pif.second_kind = 1'b0;
        pif.second_point_a = '0;
        pif.second_point_b = '0;
        pif.second_velocity = '0;
        pif.second_mass = '0;
        pif.second_static = 1'b0;
        rif.ready = 1'b0;

        // overlapping boxes, every static combination, zero mass, apart, separating
        for (int i = 0; i < 4; i++)
            pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(10, 10), pt(5, 1), 32'h10000, i[0],
                                     KIND_BOX, pt(8, 0), pt(18, 10), pt(-5, 0), 32'h30000,
                                     i[1]));
        pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(10, 10), pt(5, 0), 0, 0,
                                 KIND_BOX, pt(8, 0), pt(18, 10), pt(-5, 0), 0, 0));
        pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(10, 10), pt(5, 0), 1, 0,
                                 KIND_BOX, pt(11, 0), pt(18, 10), pt(-5, 0), 1, 0));
        pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(10, 10), pt(-5, 0), 1, 0,
                                 KIND_BOX, pt(10, 10), pt(18, 18), pt(5, 0), 1, 0));
        // coincident circles, touching circles, negative radius sum
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(7, 7), pt(3, 0), pt(1, 2), 5, 0,
                                 KIND_CIRCLE, pt(7, 7), pt(3, 0), pt(-1, 0), 5, 0));
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(0, 0), pt(3, 0), pt(9, 4), 5, 0,
                                 KIND_CIRCLE, pt(3, 4), pt(2, 0), pt(-2, -7), 9, 0));
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(0, 0), pt(-3, 0), pt(9, 4), 5, 0,
                                 KIND_CIRCLE, pt(0, 1), pt(2, 0), pt(-2, -7), 9, 0));
        // circle inside box, circle on box centre, box first vertical, inverted box
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(2, 5), pt(4, 0), pt(-30, 1), 7, 0,
                                 KIND_BOX, pt(0, 0), pt(20, 20), pt(0, 0), 3, 1));
        pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(20, 20), pt(4, 4), 7, 0,
                                 KIND_CIRCLE, pt(10, 10), pt(10, 0), pt(-3, -3), 3, 0));
        pair_q.push_back(mk_pair(KIND_BOX, pt(0, 0), pt(20, 20), pt(0, 9), 7, 1,
                                 KIND_CIRCLE, pt(10, 23), pt(4, 0), pt(0, -6), 3, 0));
        pair_q.push_back(mk_pair(KIND_BOX, pt(20, 20), pt(0, 0), pt(3, 9), 7, 0,
                                 KIND_CIRCLE, pt(10, 23), pt(40, 0), pt(0, -6), 3, 0));
        // all zeros, all ones
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pair_q.push_back(mk_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        // saturation on a full bounce, huge normal, maximum masses
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(0, 0), pt(100, 0),
                                 {32'h80000000, 32'h7fffffff}, 1, 1,
                                 KIND_CIRCLE, pt(3, 3), pt(100, 0),
                                 {32'h7fffffff, 32'h80000000}, 1, 0));
        pair_q.push_back(mk_pair(KIND_CIRCLE, pt(32'h80000000, 32'h7fffffff),
                                 pt(32'h7fffffff, 0), pt(32'h7fffffff, 32'h80000000), '1, 0,
                                 KIND_CIRCLE, pt(32'h7fffffff, 32'h80000000),
                                 pt(32'h7fffffff, 0), pt(32'h80000000, 32'h7fffffff), '1, 0));
        pair_q.push_back(mk_pair(KIND_BOX, pt(32'h80000000, 32'h80000000),
                                 pt(32'h7fffffff, 32'h7fffffff), pt(32'h7fffffff, 3), '1, 0,
                                 KIND_BOX, pt(32'h80000000, 0), pt(32'h7fffffff, 5),
                                 pt(32'h80000000, -9), 1, 0));
        for (int i = 0; i < 1530; i++)
            pair_q.push_back(rnd_pair());

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pair_q.size() == 0 && response_q.size() == 0);
        repeat (60) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pair_taken)
                void'(pair_q.pop_front());
            if (pif.valid && !pair_taken)
            begin
                // hold the beat until it is taken
            end
            else if (src_gap > 0)
            begin
                src_gap--;
                pif.valid <= 1'b0;
            end
            else if (pair_q.size() == 0
                     || (pairs_sent == DRAIN_POINT && response_q.size() != 0))
                pif.valid <= 1'b0;
            else if (pair_q.size() > 120 && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(0, 16);
                pif.valid <= 1'b0;
            end
            else
            begin
                pif.valid <= 1'b1;
                pif.first_kind <= pair_q[0].k1;
                pif.first_point_a <= pair_q[0].pa1;
                pif.first_point_b <= pair_q[0].pb1;
                pif.first_velocity <= pair_q[0].vel1;
                pif.first_mass <= pair_q[0].m1;
                pif.first_static <= pair_q[0].s1;
                pif.second_kind <= pair_q[0].k2;
                pif.second_point_a <= pair_q[0].pa2;
                pif.second_point_b <= pair_q[0].pb2;
                pif.second_velocity <= pair_q[0].vel2;
                pif.second_mass <= pair_q[0].m2;
                pif.second_static <= pair_q[0].s2;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rif.ready <= 1'b0;
            end
            else if (!hold_done && pairs_sent >= HOLD_POINT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rif.ready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                rif.ready <= 1'b0;
            end
            else if (pair_q.size() > 120 && $urandom_range(0, 9) == 0)
            begin
                snk_gap = $urandom_range(0, 16);
                rif.ready <= 1'b0;
            end
            else
                rif.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        response_t  want;
        pair_beat_t got_pair;
        pair_taken <= rst_n && pif.valid && pif.ready;
        if (rst_n)
        begin
            idle_cycles++;
            if (pif.valid && pif.ready)
            begin
                got_pair = mk_pair(pif.first_kind, pif.first_point_a, pif.first_point_b,
                                   pif.first_velocity, pif.first_mass, pif.first_static,
                                   pif.second_kind, pif.second_point_a, pif.second_point_b,
                                   pif.second_velocity, pif.second_mass,
                                   pif.second_static);
                response_q.push_back(resolve_pair(got_pair));
                pairs_sent++;
                idle_cycles = 0;
            end
            if (rif.valid && rif.ready)
            begin
                idle_cycles = 0;
                if (response_q.size() == 0)
                begin
                    $error("result beat with no pair outstanding");
                    failures++;
                end
                else
                begin
                    want = response_q.pop_front();
                    check_field("first_new_velocity", want.nv1, rif.first_new_velocity);
                    check_field("second_new_velocity", want.nv2, rif.second_new_velocity);
                    check_field("outcome", 64'(want.oc), 64'(rif.outcome));
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end
endmodule

@@ files.f @@
rtl/core/cvr_pkg.sv
rtl/core/cvr_pair_if.sv
rtl/core/cvr_result_if.sv
rtl/core/cvr_contact.sv
rtl/core/cvr_divider.sv
rtl/core/cvr_update.sv
rtl/core/collision_velocity_resolver_unit.sv
tb/tb_top.sv
